// ===== hw/rtl/dpq_pkg.sv =====
package dpq_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int URGENCY_BITS = 3;
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [15:0]             x;
    logic [15:0]             y;
    logic [15:0]             z;
    logic [URGENCY_BITS-1:0] urg;
    logic                    fluid;
    logic [15:0]             handle;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t ent;
  } slot_t;

  // broadcast to every cell for the update cycle
  typedef struct packed {
    logic pop;
    logic merge;
    logic moved;
    logic ins;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic le;
  } flags_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_MERGED   = 3'd1,
    ST_MOVED    = 3'd2,
    ST_DROPPED  = 3'd3,
    ST_POPPED   = 3'd4,
    ST_EMPTY    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_e;

endpackage

// ===== hw/rtl/dedup_priority_task_queue.sv =====
// Priority task queue of QUEUE_DEPTH entries kept as a row of cells, sorted by
// urgency (lower first, ties in arrival order) and deduplicated on the x/y/z key.
// Each word goes through a compare cycle in which every cell checks its key and
// urgency against the word, then an update cycle in which the cells shift or load
// from their neighbors; the next word is accepted on the update edge. The update
// waits while an unread result sits in the output register. Popped fields are zero
// for every status other than popped.
module dedup_priority_task_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic signed [15:0] chunk_x_i,
  input  logic signed [15:0] chunk_y_i,
  input  logic signed [15:0] chunk_z_i,
  input  logic [2:0]         urgency_i,
  input  logic               fluid_flag_i,
  input  logic [15:0]        data_handle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  output logic signed [15:0] out_z_o,
  output logic               out_fluid_o,
  output logic [15:0]        out_handle_o,
  output logic [4:0]         queue_count_o
);
  import dpq_pkg::*;

  state_e state_q, state_d;
  logic   in_ready, cmp_en, upd_en;

  logic   action_q;
  entry_t new_q;

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  status_e          status_q, status_d;
  entry_t           pop_q;

  slot_t  slots [QUEUE_DEPTH];
  slot_t  lefts [QUEUE_DEPTH];
  slot_t  rights[QUEUE_DEPTH];
  logic   gtx   [QUEUE_DEPTH];
  logic   lgtx  [QUEUE_DEPTH];
  flags_t flags [QUEUE_DEPTH];
  logic   seen  [QUEUE_DEPTH+1];
  logic [QUEUE_DEPTH-1:0] match_v, hit_v;

  cmd_t cmd;
  logic found, hit, full, empty;

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lefts[i] = '0;
      assign lgtx[i]  = 1'b0;
    end else begin : g_mid
      assign lefts[i] = slots[i-1];
      assign lgtx[i]  = gtx[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign rights[i] = '0;
    end else begin : g_inner
      assign rights[i] = slots[i+1];
    end
    assign match_v[i] = flags[i].match;
    assign hit_v[i]   = flags[i].match & flags[i].le;

    dpq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmp_en_i    (cmp_en),
      .upd_en_i    (upd_en),
      .cmd_i       (cmd),
      .new_i       (new_q),
      .left_i      (lefts[i]),
      .left_gtx_i  (lgtx[i]),
      .right_i     (rights[i]),
      .match_seen_i(seen[i]),
      .slot_o      (slots[i]),
      .gtx_o       (gtx[i]),
      .match_seen_o(seen[i+1]),
      .flags_o     (flags[i])
    );
  end

  assign found = |match_v;
  assign hit   = |hit_v;
  assign full  = slots[QUEUE_DEPTH-1].valid;
  assign empty = (count_q == '0);

  always_comb begin
    cmd.pop   = action_q && !empty;
    cmd.merge = !action_q && found && hit;
    cmd.moved = !action_q && found && !hit;
    cmd.ins   = !action_q && ((found && !hit) || (!found && !full));
  end

  always_comb begin
    if (action_q) begin
      status_d = empty ? ST_EMPTY : ST_POPPED;
    end else if (found && hit) begin
      status_d = ST_MERGED;
    end else if (found) begin
      status_d = ST_MOVED;
    end else if (full) begin
      status_d = ST_DROPPED;
    end else begin
      status_d = ST_INSERTED;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd.pop) begin
      count_d = count_q - CNT_W'(1);
    end else if (cmd.ins && !cmd.moved) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_CMP;
      S_CMP:   state_d = S_UPD;
      S_UPD: begin
        if (upd_en) state_d = in_valid_i ? S_CMP : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmp_en   = 1'b0;
    upd_en   = 1'b0;
    in_ready = 1'b0;
    case (state_q)
      S_IDLE: in_ready = 1'b1;
      S_CMP:  cmp_en = 1'b1;
      S_UPD: begin
        upd_en   = !out_valid_q || out_ready_i;
        in_ready = upd_en;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (upd_en) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready) begin
      action_q     <= action_i;
      new_q.x      <= chunk_x_i;
      new_q.y      <= chunk_y_i;
      new_q.z      <= chunk_z_i;
      new_q.urg    <= urgency_i[URGENCY_BITS-1:0];
      new_q.fluid  <= fluid_flag_i;
      new_q.handle <= data_handle_i;
    end
    if (upd_en) begin
      status_q <= status_d;
      pop_q    <= cmd.pop ? slots[0].ent : '0;
    end
  end

  assign in_ready_o    = in_ready;
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_x_o       = $signed(pop_q.x);
  assign out_y_o       = $signed(pop_q.y);
  assign out_z_o       = $signed(pop_q.z);
  assign out_fluid_o   = pop_q.fluid;
  assign out_handle_o  = pop_q.handle;
  assign queue_count_o = 5'(count_q);

endmodule

// ===== hw/rtl/dpq_cell.sv =====
module dpq_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmp_en_i,
  input  logic            upd_en_i,
  input  dpq_pkg::cmd_t   cmd_i,
  input  dpq_pkg::entry_t new_i,
  input  dpq_pkg::slot_t  left_i,
  input  logic            left_gtx_i,
  input  dpq_pkg::slot_t  right_i,
  input  logic            match_seen_i,
  output dpq_pkg::slot_t  slot_o,
  output logic            gtx_o,
  output logic            match_seen_o,
  output dpq_pkg::flags_t flags_o
);
  import dpq_pkg::*;

  logic   valid_q, valid_d;
  entry_t ent_q, ent_d;
  logic   match_q, le_q, gtx_q;
  logic   key_eq;

  assign key_eq = (ent_q.x == new_i.x) && (ent_q.y == new_i.y) && (ent_q.z == new_i.z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      le_q    <= 1'b0;
      gtx_q   <= 1'b0;
    end else if (cmp_en_i) begin
      match_q <= valid_q && key_eq;
      le_q    <= valid_q && (ent_q.urg <= new_i.urg);
      gtx_q   <= !valid_q || (ent_q.urg > new_i.urg);
    end
  end

  always_comb begin
    valid_d = valid_q;
    ent_d   = ent_q;
    if (cmd_i.pop) begin
      valid_d = right_i.valid;
      ent_d   = right_i.ent;
    end else if (cmd_i.merge) begin
      if (match_q) begin
        ent_d.handle = new_i.handle;
        ent_d.fluid  = ent_q.fluid & new_i.fluid;
      end
    end else if (cmd_i.ins) begin
      if (!(cmd_i.moved && match_seen_i) && gtx_q) begin
        if (left_gtx_i) begin
          valid_d = left_i.valid;
          ent_d   = left_i.ent;
        end else begin
          valid_d = 1'b1;
          ent_d   = new_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (upd_en_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_en_i) begin
      ent_q <= ent_d;
    end
  end

  assign slot_o       = '{valid: valid_q, ent: ent_q};
  assign gtx_o        = gtx_q;
  assign match_seen_o = match_seen_i | match_q;
  assign flags_o      = '{match: match_q, le: le_q};

endmodule
